@@ rtl/core/mrf_pkg.sv @@
// Package for the Modbus RTU response framer: frame state codes, function
// code constants, the shared context and result structs and the CRC-16 byte step.
// No dependencies.
package mrf_pkg;

	localparam logic [3:0] ST_HUNT    = 4'd0;
	localparam logic [3:0] ST_ADDR    = 4'd1;
	localparam logic [3:0] ST_FUNC    = 4'd2;
	localparam logic [3:0] ST_REGHI   = 4'd3;
	localparam logic [3:0] ST_REGLO   = 4'd4;
	localparam logic [3:0] ST_LENHI   = 4'd5;
	localparam logic [3:0] ST_LENLO   = 4'd6;
	localparam logic [3:0] ST_EXCFUNC = 4'd7;
	localparam logic [3:0] ST_EXCCODE = 4'd8;
	localparam logic [3:0] ST_PAYLOAD = 4'd9;
	localparam logic [3:0] ST_LASTPAY = 4'd10;
	localparam logic [3:0] ST_CRCLO   = 4'd11;
	localparam logic [3:0] ST_DONE    = 4'd12;

	localparam logic [7:0] FC_READ_FIRST   = 8'd1;
	localparam logic [7:0] FC_READ_LAST    = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
	localparam logic [7:0] FC_WRITE_REG    = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS   = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RST = 8'd1;

	typedef struct packed {
		logic [3:0]  state;
		logic [15:0] crc;
		logic [7:0]  crc_lo;
		logic [7:0]  pay_left;
		logic [8:0]  pos;
		logic        is_exc;
		logic        is_wr;
	} ctx_t;

	typedef struct packed {
		logic [3:0] frame_state;
		logic [7:0] echo_byte;
		logic [8:0] byte_position;
		logic       in_frame;
		logic       frame_good;
		logic       crc_fail;
		logic       exception_frame;
		logic       write_frame;
	} res_t;

	// One byte through the reflected CRC-16, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/mrf_step.sv @@
// Next-state logic of the framer: takes the current context and one byte and
// gives the next context and the result beat. Depends on mrf_pkg.
module mrf_step (
	input  mrf_pkg::ctx_t cur,
	input  logic [7:0]    dev_addr,
	input  logic [7:0]    byte_in,
	output mrf_pkg::ctx_t nxt,
	output mrf_pkg::res_t res
);

	logic       taken;
	logic       good;
	logic       fail;
	logic       data;
	logic [8:0] pos;
	logic       is_rd_code;
	logic       is_wr_code;

	assign is_rd_code = (byte_in >= mrf_pkg::FC_READ_FIRST) && (byte_in <= mrf_pkg::FC_READ_LAST);
	assign is_wr_code = (byte_in == mrf_pkg::FC_WRITE_COIL) || (byte_in == mrf_pkg::FC_WRITE_REG) ||
		(byte_in == mrf_pkg::FC_WRITE_COILS) || (byte_in == mrf_pkg::FC_WRITE_REGS);

	always_comb begin
		nxt   = cur;
		taken = 1'b1;
		good  = 1'b0;
		fail  = 1'b0;
		data  = 1'b1;
		pos   = cur.pos;
		case (cur.state)
			mrf_pkg::ST_ADDR: begin
				nxt.is_exc = 1'b0;
				nxt.is_wr  = 1'b0;
				if (byte_in[7]) begin
					nxt.is_exc = 1'b1;
					nxt.state  = mrf_pkg::ST_EXCFUNC;
				end else if (is_rd_code) begin
					nxt.state = mrf_pkg::ST_FUNC;
				end else if (is_wr_code) begin
					nxt.is_wr = 1'b1;
					nxt.state = mrf_pkg::ST_FUNC;
				end else begin
					nxt.state = mrf_pkg::ST_HUNT;
				end
			end
			mrf_pkg::ST_FUNC: begin
				if (cur.is_wr) begin
					nxt.state = mrf_pkg::ST_REGHI;
				end else begin
					nxt.pay_left = byte_in;
					nxt.state = (byte_in == 8'd0) ? mrf_pkg::ST_LASTPAY : mrf_pkg::ST_PAYLOAD;
				end
			end
			mrf_pkg::ST_REGHI:   nxt.state = mrf_pkg::ST_REGLO;
			mrf_pkg::ST_REGLO:   nxt.state = mrf_pkg::ST_LENHI;
			mrf_pkg::ST_LENHI:   nxt.state = mrf_pkg::ST_LENLO;
			mrf_pkg::ST_EXCFUNC: nxt.state = mrf_pkg::ST_EXCCODE;
			mrf_pkg::ST_PAYLOAD: begin
				nxt.pay_left = cur.pay_left - 8'd1;
				if (cur.pay_left == 8'd1) begin
					nxt.state = mrf_pkg::ST_LASTPAY;
				end
			end
			mrf_pkg::ST_LENLO, mrf_pkg::ST_EXCCODE, mrf_pkg::ST_LASTPAY: begin
				nxt.crc_lo = byte_in;
				data       = 1'b0;
				nxt.state  = mrf_pkg::ST_CRCLO;
			end
			mrf_pkg::ST_CRCLO: begin
				// This byte is the CRC high byte; the low byte was held before.
				data = 1'b0;
				if ((cur.crc_lo == cur.crc[7:0]) && (byte_in == cur.crc[15:8])) begin
					good      = 1'b1;
					nxt.state = mrf_pkg::ST_DONE;
				end else begin
					fail      = 1'b1;
					nxt.state = mrf_pkg::ST_HUNT;
				end
			end
			default: begin
				// Hunt, done and the unused codes all look for the address.
				pos = 9'd0;
				if (byte_in == dev_addr) begin
					nxt.crc    = mrf_pkg::CRC_INIT;
					nxt.is_exc = 1'b0;
					nxt.is_wr  = 1'b0;
					nxt.state  = mrf_pkg::ST_ADDR;
				end else begin
					taken = 1'b0;
					data  = 1'b0;
					if (cur.state != mrf_pkg::ST_DONE) begin
						nxt.state = mrf_pkg::ST_HUNT;
					end
				end
			end
		endcase

		if (data) begin
			nxt.crc = mrf_pkg::crc_byte(nxt.crc, byte_in);
		end
		if (taken) begin
			nxt.pos = pos + 9'd1;
		end

		res.frame_state     = nxt.state;
		res.echo_byte       = byte_in;
		res.byte_position   = pos;
		res.in_frame        = taken;
		res.frame_good      = good;
		res.crc_fail        = fail;
		res.exception_frame = nxt.is_exc;
		res.write_frame     = nxt.is_wr;
	end

endmodule

@@ rtl/core/modbus_rtu_response_framer.sv @@
// Modbus RTU response framer top level: input register, framing context,
// result register and handshakes. Depends on mrf_pkg and mrf_step.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_stall    rx_byte
//   res      out        res_valid/res_stall  frame_state .. write_frame
//   cfg      in         cfg_wr_en            cfg_wr_data (device address)
//
// One byte per cycle sustained while res is not stalled; a beat's result passes from the input
// register through the framing step into the result register, which drives the outputs.
// The framing context is updated as a byte moves from the input register into
// the result register, so consecutive bytes chain through it with no gap.
// arst_n clears the context, the device address (to 1) and both valid flags.
// A stall on res holds the result register; rx is stalled only when the
// input register is full and cannot move forward.
module modbus_rtu_response_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [3:0] frame_state,
	output logic [7:0] echo_byte,
	output logic [8:0] byte_position,
	output logic       in_frame,
	output logic       frame_good,
	output logic       crc_fail,
	output logic       exception_frame,
	output logic       write_frame
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	mrf_pkg::res_t res_s2;
	mrf_pkg::ctx_t ctx_q;
	logic [7:0]    dev_addr_q;
	mrf_pkg::ctx_t ctx_nxt;
	mrf_pkg::res_t res_nxt;
	logic          adv_s1;
	logic          take_rx;

	assign adv_s1   = valid_s1 && (!valid_s2 || !res_stall);
	assign rx_stall = valid_s1 && !adv_s1;
	assign take_rx  = rx_valid && !rx_stall;

	mrf_step u_step (
		.cur      (ctx_q),
		.dev_addr (dev_addr_q),
		.byte_in  (byte_s1),
		.nxt      (ctx_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= mrf_pkg::DEV_ADDR_RST;
		end else if (cfg_wr_en) begin
			dev_addr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_rx) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_rx) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state    <= mrf_pkg::ST_HUNT;
			ctx_q.crc      <= mrf_pkg::CRC_INIT;
			ctx_q.crc_lo   <= 8'd0;
			ctx_q.pay_left <= 8'd0;
			ctx_q.pos      <= 9'd0;
			ctx_q.is_exc   <= 1'b0;
			ctx_q.is_wr    <= 1'b0;
		end else if (adv_s1) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid       = valid_s2;
	assign frame_state     = res_s2.frame_state;
	assign echo_byte       = res_s2.echo_byte;
	assign byte_position   = res_s2.byte_position;
	assign in_frame        = res_s2.in_frame;
	assign frame_good      = res_s2.frame_good;
	assign crc_fail        = res_s2.crc_fail;
	assign exception_frame = res_s2.exception_frame;
	assign write_frame     = res_s2.write_frame;

	a_good_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_good) |-> (frame_state == mrf_pkg::ST_DONE && in_frame))
		else $error("good frame beat does not end in done");

	a_fail_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && crc_fail) |-> (frame_state == mrf_pkg::ST_HUNT && !frame_good))
		else $error("crc failure beat does not return to hunt");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !in_frame) |-> (byte_position == 9'd0))
		else $error("byte outside a frame has a nonzero position");

	a_ctx_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(ctx_q))
		else $error("framing context changed without a byte");

endmodule
